>>> rtl/tms_pkg.sv
`default_nettype none

package tms_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_WIDTH = 32;
   // Fixed widths of the channel fields
   localparam int KEY_PORT_W = 32;
   localparam int DATA_W = 32;

   localparam int TUPLE_W = KEY_WIDTH + DATA_W;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // run bounds reach lo + 2*width, below 3*CAPACITY
   localparam int POS_W = CNT_W + 2;

   typedef logic [TUPLE_W-1:0] tuple_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;

endpackage

`default_nettype wire

>>> rtl/tms_if.sv
`default_nettype none

interface tms_req_if import tms_pkg::*;;
   logic valid;
   logic ready;
   logic [KEY_PORT_W-1:0] sort_key;
   logic [DATA_W-1:0] payload;
   logic last_in;

   modport source (output valid, output sort_key, output payload, output last_in,
                   input ready);
   modport sink (input valid, input sort_key, input payload, input last_in,
                 output ready);
endinterface

interface tms_rsp_if import tms_pkg::*;;
   logic valid;
   logic ready;
   logic [KEY_PORT_W-1:0] out_key;
   logic [DATA_W-1:0] out_payload;
   logic last_out;
   logic dropped;

   modport source (output valid, output out_key, output out_payload, output last_out,
                   output dropped, input ready);
   modport sink (input valid, input out_key, input out_payload, input last_out,
                 input dropped, output ready);
endinterface

`default_nettype wire

>>> rtl/tuple_merge_sort.sv
// Sorting: a batch of n stored tuples closes with its last request; the first
//   sorted tuple follows after ceil(log2 n) merge passes.
// Throughput: loading takes 1 request per cycle, emission 1 response per cycle
//   while rsp_ch.ready is held; no requests are taken until the batch is emitted.
// Reset (synchronous, active high) clears state, fill, overflow flag and rsp valid only.
`default_nettype none

module tuple_merge_sort import tms_pkg::*; (
   input  logic clock,
   input  logic reset,
   tms_req_if.sink   req_ch,
   tms_rsp_if.source rsp_ch
);

   // Sequencer states
   localparam logic [1:0] S_LOAD  = 2'd0;  // take requests into memory A
   localparam logic [1:0] S_SETUP = 2'd1;  // open next merge, or start emission
   localparam logic [1:0] S_MERGE = 2'd2;  // one merged tuple per cycle
   localparam logic [1:0] S_EMIT  = 2'd3;  // stream sorted tuples out

   logic [1:0] state_ff, state_in;
   cnt_type    fill_ff, fill_in;     // tuples held in this batch
   logic       ovf_ff, ovf_in;       // sticky: a tuple of this batch was dropped
   logic       src_ff, src_in;       // 0: memory A holds the current runs
   pos_type    width_ff, width_in;   // run length of the current pass
   pos_type    lo_ff, lo_in;         // start of the current run pair
   pos_type    mid_ff, mid_in;       // end of left run
   pos_type    hi_ff, hi_in;         // end of right run
   pos_type    i_ff, i_in;           // left head; emit index during S_EMIT
   pos_type    j_ff, j_in;           // right head
   pos_type    k_ff, k_in;           // merge write position

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_PORT_W-1:0] rsp_key_ff, rsp_key_in;
   logic [DATA_W-1:0]     rsp_pay_ff, rsp_pay_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_drop_ff, rsp_drop_in;

   // Ping-pong tuple memories, two read ports each, registered read data.
   // Both are read at the same two addresses; src_ff picks the one in use.
   tuple_type mem_a [CAPACITY];
   tuple_type mem_b [CAPACITY];
   tuple_type qa_l_ff, qa_r_ff, qb_l_ff, qb_r_ff;

   logic      wa_en, wb_en;
   addr_type  w_addr;
   tuple_type w_data;
   addr_type  rd_l, rd_r;

   tuple_type q_l, q_r;
   logic      take_left;
   logic      req_fire;
   logic      emit_load;
   pos_type   n;
   pos_type   sum_mid, sum_hi;

   assign rd_l = i_in[ADDR_W-1:0];
   assign rd_r = j_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wa_en) begin
         mem_a[w_addr] <= w_data;
      end
      qa_l_ff <= mem_a[rd_l];
      qa_r_ff <= mem_a[rd_r];
   end

   always_ff @(posedge clock) begin
      if (wb_en) begin
         mem_b[w_addr] <= w_data;
      end
      qb_l_ff <= mem_b[rd_l];
      qb_r_ff <= mem_b[rd_r];
   end

   assign q_l = src_ff ? qb_l_ff : qa_l_ff;
   assign q_r = src_ff ? qb_r_ff : qa_r_ff;

   assign n = pos_type'(fill_ff);

   // Stable merge: on equal keys the left run goes first.
   assign take_left = (i_ff < mid_ff) &&
                      ((j_ff >= hi_ff) ||
                       (q_l[TUPLE_W-1 -: KEY_WIDTH] <= q_r[TUPLE_W-1 -: KEY_WIDTH]));

   assign req_ch.ready = (state_ff == S_LOAD);
   assign req_fire = req_ch.valid && req_ch.ready;

   // The emit read address only moves when the response register takes q_l,
   // so a stalled response just re-reads the same entry.
   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   assign sum_mid = lo_ff + width_ff;
   assign sum_hi = lo_ff + (width_ff << 1);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      ovf_in = ovf_ff;
      src_in = src_ff;
      width_in = width_ff;
      lo_in = lo_ff;
      mid_in = mid_ff;
      hi_in = hi_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      wa_en = 1'b0;
      wb_en = 1'b0;
      w_addr = k_ff[ADDR_W-1:0];
      w_data = take_left ? q_l : q_r;

      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_key_in = rsp_key_ff;
      rsp_pay_in = rsp_pay_ff;
      rsp_last_in = rsp_last_ff;
      rsp_drop_in = rsp_drop_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (fill_ff < cnt_type'(CAPACITY)) begin
                  wa_en = 1'b1;
                  w_addr = fill_ff[ADDR_W-1:0];
                  w_data = {req_ch.sort_key[KEY_WIDTH-1:0], req_ch.payload};
                  fill_in = fill_ff + cnt_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.last_in) begin
                  state_in = S_SETUP;
                  width_in = pos_type'(1);
                  lo_in = '0;
                  src_in = 1'b0;
               end
            end
         end
         S_SETUP: begin
            if (width_ff >= n) begin
               // sorted; read of entry 0 issued here
               state_in = S_EMIT;
               i_in = '0;
            end else begin
               mid_in = (sum_mid < n) ? sum_mid : n;
               hi_in = (sum_hi < n) ? sum_hi : n;
               i_in = lo_ff;
               j_in = mid_in;
               k_in = lo_ff;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            if (src_ff) begin
               wa_en = 1'b1;
            end else begin
               wb_en = 1'b1;
            end
            i_in = i_ff + pos_type'(take_left);
            j_in = j_ff + pos_type'(!take_left);
            k_in = k_ff + pos_type'(1);
            if (k_ff == hi_ff - pos_type'(1)) begin
               state_in = S_SETUP;
               if (hi_ff >= n) begin
                  // pass done: double the runs, swap memories
                  width_in = width_ff << 1;
                  lo_in = '0;
                  src_in = !src_ff;
               end else begin
                  lo_in = hi_ff;
               end
            end
         end
         S_EMIT: begin
            if (emit_load) begin
               i_in = i_ff + pos_type'(1);
               rsp_valid_in = 1'b1;
               rsp_key_in = KEY_PORT_W'(q_l[TUPLE_W-1 -: KEY_WIDTH]);
               rsp_pay_in = q_l[DATA_W-1:0];
               rsp_last_in = (i_ff == n - pos_type'(1));
               rsp_drop_in = ovf_ff;
               if (i_ff == n - pos_type'(1)) begin
                  state_in = S_LOAD;
                  fill_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         fill_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      width_ff <= width_in;
      lo_ff <= lo_in;
      mid_ff <= mid_in;
      hi_ff <= hi_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      rsp_key_ff <= rsp_key_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_key = rsp_key_ff;
   assign rsp_ch.out_payload = rsp_pay_ff;
   assign rsp_ch.last_out = rsp_last_ff;
   assign rsp_ch.dropped = rsp_drop_ff;

endmodule

`default_nettype wire
